/* hw/rtl/bc_pkg.sv */
// ----------------------------------------------------------------------------
// bc_pkg
// Shared constants for the binomial coefficient unit.
// ----------------------------------------------------------------------------
package bc_pkg;

	// width of every payload field on the channels
	localparam int FIELD_W = 64;

	// default arithmetic word width
	localparam int WORD_BITS_DEF = 64;

endpackage

/* hw/rtl/bc_ifs.sv */
// ----------------------------------------------------------------------------
// bc_ifs
// Valid/ready channel interfaces for requests (n, k) and responses C(n,k).
// ----------------------------------------------------------------------------
interface bc_req_if import bc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] top;
	logic [FIELD_W-1:0] choose;

	modport source (output valid, output top, output choose, input ready);
	modport sink   (input valid, input top, input choose, output ready);
endinterface

interface bc_rsp_if import bc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] coefficient;

	modport source (output valid, output coefficient, input ready);
	modport sink   (input valid, input coefficient, output ready);
endinterface

/* hw/rtl/bc_div.sv */
// ----------------------------------------------------------------------------
// bc_div
// Bit-serial restoring divider: one quotient bit per cycle, giving quotient
// and remainder.
// ----------------------------------------------------------------------------
module bc_div #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	// one restoring step
	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

/* hw/rtl/binomial_coefficient_top.sv */
// ----------------------------------------------------------------------------
// binomial_coefficient_top
// Computes C(n,k) by the multiplicative method with gcd reduction.
// ----------------------------------------------------------------------------
// Usage:
//   req carries n (top) and k (choose); rsp returns the coefficient, or 0
//   when the result would not fit in WORD_BITS bits. One response per request,
//   in order. Only the low WORD_BITS bits of the inputs are used.
//   req.ready is high only while the unit is idle; a request is taken, then
//   the unit works on it alone until its response has been transferred.
// Sequence:
//   Trivial cases (k of 0 or 1, k not below n) go from S_CHECK straight to
//   S_OUT and raise rsp.valid. Otherwise each of the up to about 34 steps
//   does a division for the overflow bound, a shift-add multiply and a
//   division; steps needing reduction add five more divisions and one
//   division per Euclid round. All divisions run in turn on the single
//   shared bit-serial divider.
// Reset: arst_n clears the sequencer; the unit comes up idle and ready.
// Stall: a held response stays on rsp unchanged until taken.
// ----------------------------------------------------------------------------
module binomial_coefficient_top import bc_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bc_req_if.sink    req,
	bc_rsp_if.source  rsp
);

	localparam int W  = WORD_BITS;
	localparam int CW = $clog2(W + 1);
	localparam logic [W-1:0] WMAX = {W{1'b1}};
	localparam logic [W-1:0] ONE  = W'(1);

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_MIRROR, S_LOOP, S_QMAX, S_CMP, S_MUL, S_DIVD,
		S_EUC_INIT, S_EUC, S_NUM, S_DEN, S_RG, S_DG, S_QNUM, S_CMP2, S_OUT
	} state_t;

	state_t        state_q;
	logic [W-1:0]  n_q, k_q, d_q, r_q, num_q, den_q, ga_q, gb_q, q_q, res_q;
	logic [W-1:0]  acc_q, ma_q, mb_q;
	logic [CW-1:0] mcnt_q;
	logic          pend_q;
	logic          gsel_q;
	logic          path_q;

	logic          div_start, div_busy, div_done;
	logic [W-1:0]  div_a, div_b, div_q, div_r;
	logic [W-1:0]  mul_op;

	// divider operand selection per state
	always_comb begin
		div_a = r_q;
		div_b = d_q;
		case (state_q)
			S_QMAX: begin div_a = WMAX; div_b = n_q; end
			S_DIVD: begin div_a = r_q;  div_b = path_q ? den_q : d_q; end
			S_EUC:  begin div_a = ga_q; div_b = gb_q; end
			S_NUM:  begin div_a = n_q;  div_b = ga_q; end
			S_DEN:  begin div_a = d_q;  div_b = ga_q; end
			S_RG:   begin div_a = r_q;  div_b = ga_q; end
			S_DG:   begin div_a = den_q; div_b = ga_q; end
			S_QNUM: begin div_a = WMAX; div_b = num_q; end
			default: begin div_a = r_q; div_b = d_q; end
		endcase
	end

	assign div_start = !pend_q && (state_q inside {S_QMAX, S_DIVD, S_NUM, S_DEN,
		S_RG, S_DG, S_QNUM} || (state_q == S_EUC && gb_q != '0));
	assign mul_op = path_q ? num_q : n_q;

	bc_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						n_q     <= req.top[W-1:0];
						k_q     <= req.choose[W-1:0];
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (k_q == '0) begin
						res_q   <= ONE;
						state_q <= S_OUT;
					end else if (k_q == ONE) begin
						res_q   <= n_q;
						state_q <= S_OUT;
					end else if (k_q >= n_q) begin
						res_q   <= (k_q == n_q) ? ONE : '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_MIRROR;
					end
				end
				S_MIRROR: begin
					if (k_q > (n_q >> 1))
						k_q <= n_q - k_q;
					d_q     <= ONE;
					r_q     <= ONE;
					state_q <= S_LOOP;
				end
				S_LOOP: begin
					if (d_q > k_q) begin
						res_q   <= r_q;
						state_q <= S_OUT;
					end else begin
						state_q <= S_QMAX;
					end
				end
				S_QMAX, S_QNUM: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (div_done) begin
						pend_q  <= 1'b0;
						q_q     <= div_q;
						state_q <= (state_q == S_QMAX) ? S_CMP : S_CMP2;
					end
				end
				S_CMP: begin
					if (r_q >= q_q) begin
						gsel_q  <= 1'b0;
						state_q <= S_EUC_INIT;
					end else begin
						path_q  <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_CMP2: begin
					if (r_q >= q_q) begin
						res_q   <= '0;
						state_q <= S_OUT;
					end else begin
						path_q  <= 1'b1;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
						acc_q  <= '0;
						ma_q   <= r_q;
						mb_q   <= mul_op;
						mcnt_q <= '0;
					end else if (mcnt_q != CW'(W)) begin
						if (mb_q[0])
							acc_q <= acc_q + ma_q;
						ma_q   <= ma_q << 1;
						mb_q   <= mb_q >> 1;
						mcnt_q <= mcnt_q + 1'b1;
					end else begin
						pend_q  <= 1'b0;
						r_q     <= acc_q;
						state_q <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (div_done) begin
						pend_q  <= 1'b0;
						r_q     <= div_q;
						n_q     <= n_q - 1'b1;
						d_q     <= d_q + 1'b1;
						state_q <= S_LOOP;
					end
				end
				S_EUC_INIT: begin
					// smaller operand first
					if (!gsel_q) begin
						ga_q <= (d_q < n_q) ? d_q : n_q;
						gb_q <= (d_q < n_q) ? n_q : d_q;
					end else begin
						ga_q <= (den_q < r_q) ? den_q : r_q;
						gb_q <= (den_q < r_q) ? r_q : den_q;
					end
					state_q <= S_EUC;
				end
				S_EUC: begin
					if (gb_q == '0 && !pend_q) begin
						path_q  <= 1'b1;
						state_q <= gsel_q ? S_RG : S_NUM;
					end else if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (div_done) begin
						pend_q <= 1'b0;
						ga_q   <= gb_q;
						gb_q   <= div_r;
					end
				end
				S_NUM, S_DEN, S_RG, S_DG: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (div_done) begin
						pend_q <= 1'b0;
						case (state_q)
							S_NUM: begin
								num_q   <= div_q;
								state_q <= S_DEN;
							end
							S_DEN: begin
								den_q   <= div_q;
								gsel_q  <= 1'b1;
								state_q <= S_EUC_INIT;
							end
							S_RG: begin
								r_q     <= div_q;
								state_q <= S_DG;
							end
							default: begin
								den_q   <= div_q;
								state_q <= S_QNUM;
							end
						endcase
					end
				end
				S_OUT: begin
					if (rsp.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = (state_q == S_OUT);
	assign rsp.coefficient = FIELD_W'(res_q);

`ifndef NO_ASSERTIONS
	// the divider is never restarted mid-division
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// an accepted request always moves on to the case check
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_CHECK))
		else $error("request accepted without starting");

	// a division result only arrives while one is outstanding
	a_done_pend: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> pend_q)
		else $error("division result with no request pending");
`endif

endmodule

/* tb/binomial_coefficient_checker.sv */
// ----------------------------------------------------------------------------
// binomial_coefficient_checker
// Watches the request and response channels of the binomial coefficient unit,
// computes C(n,k) for every request transfer and compares each response
// transfer with the oldest outstanding coefficient.
// ----------------------------------------------------------------------------
module binomial_coefficient_checker import bc_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bc_req_if    req,
	bc_rsp_if    rsp,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - WORD_BITS);

	logic [63:0] coeff_q[$];

	// Euclidean gcd
	function automatic logic [63:0] gcd_of(logic [63:0] a, logic [63:0] b);
		logic [63:0] t;
		if (b < a) begin
			t = a;
			a = b;
			b = t;
		end
		while (b > 0) begin
			t = b;
			b = a % b;
			a = t;
		end
		return a;
	endfunction

	// multiplicative C(n,k) with gcd reduction and cautious overflow test
	function automatic logic [63:0] binomial(logic [63:0] n, logic [63:0] k);
		logic [63:0] r, d, g, num, den;
		r = 1;
		if (k == 0) return 1;
		if (k == 1) return n;
		if (k >= n) return (k == n) ? 64'd1 : 64'd0;
		if (k > n / 2) k = n - k;
		for (d = 1; d <= k; d++) begin
			if (r >= WORD_MASK / n) begin
				g   = gcd_of(n, d);
				num = n / g;
				den = d / g;
				g   = gcd_of(r, den);
				r   = r / g;
				den = den / g;
				if (r >= WORD_MASK / num) return 0;
				r = (r * num) & WORD_MASK;
				r = r / den;
			end else begin
				r = (r * n) & WORD_MASK;
				r = r / d;
			end
			n--;
		end
		return r;
	endfunction

	assign pending = coeff_q.size();

	// predict on request transfer, compare on response transfer
	always @(posedge clk) begin
		logic [63:0] want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (req.valid && req.ready)
				coeff_q.push_back(binomial(req.top & WORD_MASK, req.choose & WORD_MASK)
					& WORD_MASK);
			if (rsp.valid && rsp.ready) begin
				if (coeff_q.size() == 0) begin
					$display("%t: unexpected coefficient %0d", $realtime, rsp.coefficient);
					fail_count <= fail_count + 1;
				end else begin
					want = coeff_q.pop_front();
					if (rsp.coefficient !== want) begin
						$display("%t: coefficient expected %0d actual %0d",
							$realtime, want, rsp.coefficient);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

/* tb/binomial_coefficient_top_test.sv */
// ----------------------------------------------------------------------------
// binomial_coefficient_top_test
// Drives directed and random (n, k) requests into the binomial coefficient
// unit with random idle bursts on both channels; the checker predicts and
// compares every coefficient. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module binomial_coefficient_top_test import bc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 100;
	localparam int STALL_LIMIT  = 300000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   calm;
	int   quiet_cycles;

	bc_req_if req ();
	bc_rsp_if rsp ();

	binomial_coefficient_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	binomial_coefficient_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// response back-pressure in random bursts
	always @(posedge clk or negedge arst_n) begin
		int burst;
		if (!arst_n) begin
			rsp.ready <= 1'b1;
			burst = 0;
		end else if (calm) begin
			rsp.ready <= 1'b1;
		end else if (burst > 0) begin
			burst--;
		end else begin
			burst = $urandom_range(1, 16);
			rsp.ready <= ($urandom_range(0, 2) != 0);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("binomial_coefficient_top_test: errors");
			$finish;
		end
	end

	// one request transfer, optionally preceded by an idle burst
	task automatic send(logic [63:0] n, logic [63:0] k);
		if (!calm && $urandom_range(0, 2) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req.valid  <= 1'b1;
		req.top    <= n;
		req.choose <= k;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		logic [63:0] n, k;
		quiet_cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		req.valid  <= 1'b0;
		req.top    <= '0;
		req.choose <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes and special cases
		send(0, 0);
		send(64'hFFFF_FFFF_FFFF_FFFF, 0);
		send(0, 1);
		send(64'hFFFF_FFFF_FFFF_FFFF, 1);
		send(7, 7);
		send(3, 9);
		send(0, 64'hFFFF_FFFF_FFFF_FFFF);
		send(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
		send(64'hFFFF_FFFF_FFFF_FFFF, 2);
		send(64'h0000_0001_0000_0000, 2);
		send(10, 7);
		send(20, 10);
		send(62, 31);
		send(66, 33);
		send(67, 33);
		send(68, 34);
		send(100, 50);
		send(1000, 5);
		send(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);

		// random part: mostly small n, some full-width words
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i > RANDOM_ITEMS - 15) calm = 1'b1;
			case ($urandom_range(0, 5))
				0: begin
					n = rand_word();
					k = rand_word();
				end
				1: begin
					n = rand_word() >> $urandom_range(0, 63);
					k = $urandom_range(0, 8);
				end
				default: begin
					n = $urandom_range(0, 75);
					k = $urandom_range(0, n + 2);
				end
			endcase
			send(n, k);
		end
		req.valid <= 1'b0;

		// let the checker record the last transfer before draining
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("binomial_coefficient_top_test: clean");
		else
			$display("binomial_coefficient_top_test: errors");
		$finish;
	end
endmodule
